// ===== hw/rtl/ils_pkg.sv =====
`default_nettype none

package ils_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int OP_W     = 3;
    localparam int LEN_W    = 9;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    localparam logic [OP_W-1:0] OP_READ     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] READ_MISS = -32'sd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_INS_SHIFT,
        S_INS_PUT,
        S_DEL_SHIFT,
        S_HOLD
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/indexed_list_store.sv =====
// Ordered list store of up to CAPACITY signed 32-bit values.
//
// The input channel (s_valid, s_ready) carries one request word: an op
// code, a position and a value. The result channel (m_valid, m_ready)
// returns one word per request: the read value, a status and the list
// length after the request.
//
// The list lives in a single-port-write, single-port-read RAM with a
// registered read. Inserts and deletes move entries one per cycle, a
// read of entry k overlapping the write of its neighbor.
// Rejected or unknown requests and deletes of the tail finish without a
// RAM access; a read in range waits for the registered RAM read. An insert
// moves the entries from the tail down to its position up by one, then
// writes the value; a delete moves the entries after its position down.
// One request is in work at a time. A new request is taken once the
// previous result is in the output register, even if the receiver has
// not taken it.
// A finished result that meets a full output register waits in a hold
// register. Reset empties the list; the RAM itself is not cleared.
`default_nettype none

module indexed_list_store
    import ils_pkg::*;
(
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire        [OP_W-1:0]     s_op,
    input  wire        [LEN_W-1:0]    s_index,
    input  wire signed [DATA_W-1:0]   s_value,
    output logic                      m_valid,
    input  wire                       m_ready,
    output logic signed [DATA_W-1:0]  m_read_value,
    output logic       [STAT_W-1:0]   m_status,
    output logic       [LEN_W-1:0]    m_length
);

    logic signed [DATA_W-1:0] mem [CAPACITY];

    state_t state_reg, state_next;
    logic [LEN_W-1:0]         count_reg, count_next;
    logic [ADDR_W-1:0]        ptr_reg, ptr_next;
    logic [ADDR_W-1:0]        pos_reg, pos_next;
    logic signed [DATA_W-1:0] val_reg, val_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_rd_reg, m_rd_next;
    logic [STAT_W-1:0]        m_st_reg, m_st_next;
    logic [LEN_W-1:0]         m_len_reg, m_len_next;

    logic signed [DATA_W-1:0] res_rd_reg, res_rd_next;
    logic [STAT_W-1:0]        res_st_reg, res_st_next;
    logic [LEN_W-1:0]         res_len_reg, res_len_next;

    logic                     mem_we, mem_re;
    logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic signed [DATA_W-1:0] mem_rdata_reg;

    logic                     fin;
    logic signed [DATA_W-1:0] fin_rd;
    logic [STAT_W-1:0]        fin_st;

    logic             accept, out_free, is_full;
    logic [LEN_W-1:0] ins_pos, count_m1;
    logic             ins_op, ins_range, ins_ok, idx_in, del_more, ins_more;
    logic             ins_last, del_last;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign is_full   = (count_reg == CAP_LEN);
    assign count_m1  = count_reg - LEN_W'(1);
    assign idx_in    = (s_index < count_reg);
    assign ins_op    = (s_op == OP_INS_HEAD) || (s_op == OP_INS_TAIL) || (s_op == OP_INS_AT);
    assign ins_range = (s_op == OP_INS_AT) && (s_index > count_reg);
    assign ins_ok    = ins_op && !ins_range && !is_full;
    assign ins_more  = (count_reg > ins_pos);
    assign del_more  = (s_index < count_m1);
    assign ins_last  = (ptr_reg == pos_reg);
    assign del_last  = ({1'b0, ptr_reg} == count_m1);

    always_comb begin
        case (s_op)
            OP_INS_HEAD: ins_pos = '0;
            OP_INS_TAIL: ins_pos = count_reg;
            default:     ins_pos = s_index;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_op == OP_READ && idx_in) begin
                        state_next = S_READ;
                    end else if (ins_ok) begin
                        state_next = ins_more ? S_INS_SHIFT : S_INS_PUT;
                    end else if (s_op == OP_DELETE && idx_in && del_more) begin
                        state_next = S_DEL_SHIFT;
                    end else begin
                        state_next = out_free ? S_IDLE : S_HOLD;
                    end
                end
            end
            S_READ: state_next = out_free ? S_IDLE : S_HOLD;
            S_INS_SHIFT: begin
                if (ins_last) begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT: state_next = out_free ? S_IDLE : S_HOLD;
            S_DEL_SHIFT: begin
                if (del_last) begin
                    state_next = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = '0;
        mem_raddr  = '0;
        mem_wdata  = val_reg;
        fin        = 1'b0;
        fin_rd     = '0;
        fin_st     = STAT_OK;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    val_next = s_value;
                    pos_next = ins_pos[ADDR_W-1:0];
                    if (s_op == OP_READ && idx_in) begin
                        mem_re    = 1'b1;
                        mem_raddr = s_index[ADDR_W-1:0];
                    end else if (ins_ok) begin
                        if (ins_more) begin
                            mem_re    = 1'b1;
                            mem_raddr = count_m1[ADDR_W-1:0];
                            ptr_next  = count_m1[ADDR_W-1:0];
                        end
                    end else if (s_op == OP_DELETE && idx_in) begin
                        if (del_more) begin
                            mem_re    = 1'b1;
                            mem_raddr = s_index[ADDR_W-1:0] + ADDR_W'(1);
                            ptr_next  = s_index[ADDR_W-1:0] + ADDR_W'(1);
                        end else begin
                            count_next = count_m1;
                            fin        = 1'b1;
                        end
                    end else begin
                        fin = 1'b1;
                        if (s_op == OP_READ) begin
                            fin_rd = READ_MISS;
                            fin_st = STAT_RANGE;
                        end else if (ins_op && !ins_range) begin
                            fin_st = STAT_FULL;
                        end else begin
                            fin_st = STAT_RANGE;
                        end
                    end
                end
            end
            S_READ: begin
                fin    = 1'b1;
                fin_rd = mem_rdata_reg;
            end
            S_INS_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg + ADDR_W'(1);
                mem_wdata = mem_rdata_reg;
                if (!ins_last) begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg - ADDR_W'(1);
                    ptr_next  = ptr_reg - ADDR_W'(1);
                end
            end
            S_INS_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + LEN_W'(1);
                fin        = 1'b1;
            end
            S_DEL_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg - ADDR_W'(1);
                mem_wdata = mem_rdata_reg;
                if (del_last) begin
                    count_next = count_m1;
                    fin        = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + ADDR_W'(1);
                    ptr_next  = ptr_reg + ADDR_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_rd_next    = m_rd_reg;
        m_st_next    = m_st_reg;
        m_len_next   = m_len_reg;
        res_rd_next  = res_rd_reg;
        res_st_next  = res_st_reg;
        res_len_next = res_len_reg;
        if (state_reg == S_HOLD) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_rd_next    = res_rd_reg;
                m_st_next    = res_st_reg;
                m_len_next   = res_len_reg;
            end
        end else if (fin) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_rd_next    = fin_rd;
                m_st_next    = fin_st;
                m_len_next   = count_next;
            end else begin
                res_rd_next  = fin_rd;
                res_st_next  = fin_st;
                res_len_next = count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        m_rd_reg    <= m_rd_next;
        m_st_reg    <= m_st_next;
        m_len_reg   <= m_len_next;
        res_rd_reg  <= res_rd_next;
        res_st_reg  <= res_st_next;
        res_len_reg <= res_len_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_rd_reg;
    assign m_status     = m_st_reg;
    assign m_length     = m_len_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ils_checker.sv =====
`default_nettype none

module ils_checker
    import ils_pkg::*;
(
    input wire                     aclk,
    input wire                     aresetn,
    input wire                     m_valid,
    input wire                     m_ready,
    input wire signed [DATA_W-1:0] m_read_value,
    input wire        [STAT_W-1:0] m_status,
    input wire        [LEN_W-1:0]  m_length
);

    // A word left waiting on the result channel stays until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // The output register comes up empty after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present right after reset");

    // A full status is only reported when the list holds CAPACITY entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_FULL |-> m_length == CAP_LEN)
        else $error("full status with a list that is not full");

    // A nonzero read value with a range error can only be the read miss marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_RANGE && m_read_value != 0
            |-> m_read_value == READ_MISS)
        else $error("range error with a stray read value");

    // The length never exceeds the capacity and the status is never the unused code 3.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_length <= CAP_LEN && m_status != 2'd3)
        else $error("length or status out of bounds");

endmodule

bind indexed_list_store ils_checker u_ils_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_value (m_read_value),
    .m_status     (m_status),
    .m_length     (m_length)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import ils_pkg::*;

    localparam int RANDOM_WORDS   = 830;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = CAPACITY + 16;
    localparam int QUIET_FIRST    = 300;
    localparam int QUIET_LAST     = 420;
    localparam int HOLD_AT_FULL   = 40;

    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_DELETE + 1'b1;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = '1;
    localparam logic [LEN_W-1:0] INDEX_MAX      = '1;
    localparam logic [LEN_W-1:0] INDEX_CAP      = CAP_LEN;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic        [STAT_W-1:0] status;
        logic        [LEN_W-1:0]  length;
    } result_t;

    typedef struct packed {
        logic        [OP_W-1:0]   op;
        logic        [LEN_W-1:0]  index;
        logic signed [DATA_W-1:0] value;
        logic                     typed;
        result_t                  want;
    } directed_row_t;

    typedef enum logic [1:0] {
        FILL,
        AT_CAPACITY,
        DRAIN,
        MIXED
    } fill_mode_t;

    localparam result_t UNTYPED = '0;

    localparam directed_row_t DIRECTED [23] = '{
        '{OP_READ,         9'd0,     32'sd0,          1'b1, '{READ_MISS, STAT_RANGE, 9'd0}},
        '{OP_DELETE,       9'd0,     32'sd0,          1'b1, '{32'sd0, STAT_RANGE, 9'd0}},
        '{OP_INS_AT,       9'd1,     32'sd7,          1'b1, '{32'sd0, STAT_RANGE, 9'd0}},
        '{OP_UNUSED_FIRST, 9'd0,     32'sd9,          1'b1, '{32'sd0, STAT_RANGE, 9'd0}},
        '{OP_UNUSED_LAST,  INDEX_MAX, VAL_MAX,        1'b1, '{32'sd0, STAT_RANGE, 9'd0}},
        '{OP_INS_HEAD,     9'd0,     VAL_MAX,         1'b1, '{32'sd0, STAT_OK, 9'd1}},
        '{OP_INS_TAIL,     INDEX_MAX, VAL_MIN,        1'b1, '{32'sd0, STAT_OK, 9'd2}},
        '{OP_INS_AT,       9'd1,     -32'sd1,         1'b1, '{32'sd0, STAT_OK, 9'd3}},
        '{OP_INS_AT,       9'd3,     32'sd0,          1'b1, '{32'sd0, STAT_OK, 9'd4}},
        '{OP_INS_AT,       9'd0,     32'sh5A5A_5A5A,  1'b0, UNTYPED},
        '{OP_READ,         9'd0,     VAL_MIN,         1'b0, UNTYPED},
        '{OP_READ,         9'd1,     32'sd0,          1'b0, UNTYPED},
        '{OP_READ,         9'd2,     32'sd0,          1'b0, UNTYPED},
        '{OP_READ,         9'd3,     32'sd0,          1'b0, UNTYPED},
        '{OP_READ,         9'd5,     32'sd0,          1'b1, '{READ_MISS, STAT_RANGE, 9'd5}},
        '{OP_READ,         INDEX_MAX, 32'sd0,         1'b1, '{READ_MISS, STAT_RANGE, 9'd5}},
        '{OP_DELETE,       INDEX_MAX, 32'sd0,         1'b1, '{32'sd0, STAT_RANGE, 9'd5}},
        '{OP_INS_AT,       INDEX_MAX, -32'sd1,        1'b1, '{32'sd0, STAT_RANGE, 9'd5}},
        '{OP_DELETE,       9'd4,     32'sd0,          1'b0, UNTYPED},
        '{OP_DELETE,       9'd0,     32'sd0,          1'b0, UNTYPED},
        '{OP_INS_AT,       INDEX_CAP, 32'sd3,         1'b1, '{32'sd0, STAT_RANGE, 9'd3}},
        '{OP_READ,         INDEX_CAP, 32'sd0,         1'b1, '{READ_MISS, STAT_RANGE, 9'd3}},
        '{OP_DELETE,       9'd1,     32'sd0,          1'b0, UNTYPED}
    };

    logic                     aclk    = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic        [OP_W-1:0]   s_op    = OP_READ;
    logic        [LEN_W-1:0]  s_index = '0;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_read_value;
    logic        [STAT_W-1:0] m_status;
    logic        [LEN_W-1:0]  m_length;

    logic idle_en = 1'b1;
    int   mismatches = 0;
    int   idle_cycles = 0;
    int   results_seen = 0;

    logic signed [DATA_W-1:0] shadow_list [CAPACITY];
    int                       shadow_len = 0;
    result_t                  pending_results [$];

    indexed_list_store uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_index      (s_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_length     (m_length)
    );

    always #1 aclk = ~aclk;

    // Applies one request to the shadow list and returns the word it should produce.
    function automatic result_t track_request(input logic [OP_W-1:0] op,
                                              input logic [LEN_W-1:0] index,
                                              input logic signed [DATA_W-1:0] value);
        result_t r;
        int      pos;
        r.read_value = '0;
        r.status     = STAT_OK;
        pos          = int'(index);
        case (op)
            OP_READ: begin
                if (pos < shadow_len) begin
                    r.read_value = shadow_list[pos];
                end else begin
                    r.read_value = READ_MISS;
                    r.status     = STAT_RANGE;
                end
            end
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
                if (op == OP_INS_HEAD) begin
                    pos = 0;
                end else if (op == OP_INS_TAIL) begin
                    pos = shadow_len;
                end
                if (pos > shadow_len) begin
                    r.status = STAT_RANGE;
                end else if (shadow_len >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    for (int k = shadow_len; k > pos; k--) begin
                        shadow_list[k] = shadow_list[k-1];
                    end
                    shadow_list[pos] = value;
                    shadow_len++;
                end
            end
            OP_DELETE: begin
                if (pos < shadow_len) begin
                    for (int k = pos; k + 1 < shadow_len; k++) begin
                        shadow_list[k] = shadow_list[k+1];
                    end
                    shadow_len--;
                end else begin
                    r.status = STAT_RANGE;
                end
            end
            default: begin
                r.status = STAT_RANGE;
            end
        endcase
        r.length = LEN_W'(shadow_len);
        return r;
    endfunction

    function automatic logic [OP_W-1:0] choose_op(input int ins_pct, input int del_pct,
                                                  input int read_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
            case ($urandom_range(0, 2))
                0:       return OP_INS_HEAD;
                1:       return OP_INS_TAIL;
                default: return OP_INS_AT;
            endcase
        end else if (roll < ins_pct + del_pct) begin
            return OP_DELETE;
        end else if (roll < ins_pct + del_pct + read_pct) begin
            return OP_READ;
        end
        return OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    endfunction

    function automatic logic [LEN_W-1:0] pick_index(input int len);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return LEN_W'($urandom_range(0, len));
        end else if (roll < 80) begin
            return LEN_W'(len + $urandom_range(0, 1));
        end
        return LEN_W'($urandom_range(0, INDEX_MAX));
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MAX;
                1:       return VAL_MIN;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] index,
                                input logic signed [DATA_W-1:0] value,
                                input logic typed, input result_t want);
        result_t predicted;
        if (idle_en) begin
            while ($urandom_range(0, 99) < 30) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_index <= index;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = track_request(op, index, value);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        m_ready <= !idle_en || ($urandom_range(0, 99) >= 30);
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word %0d arrived with none expected",
                                          results_seen));
            end else begin
                want = pending_results.pop_front();
                if (m_read_value !== want.read_value) begin
                    report_mismatch($sformatf("word %0d read_value %0d, expected %0d",
                                              results_seen, m_read_value, want.read_value));
                end
                if (m_status !== want.status) begin
                    report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                              results_seen, m_status, want.status));
                end
                if (m_length !== want.length) begin
                    report_mismatch($sformatf("word %0d length %0d, expected %0d",
                                              results_seen, m_length, want.length));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("indexed_list_store verification failed");
            $finish;
        end
    end

    initial begin
        fill_mode_t        mode;
        int                held;
        logic [OP_W-1:0]   op;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            send_request(DIRECTED[i].op, DIRECTED[i].index, DIRECTED[i].value,
                         DIRECTED[i].typed, DIRECTED[i].want);
        end

        // Grow the list to capacity, dwell there, drain it, then mix freely.
        mode = FILL;
        held = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            idle_en <= !(n >= QUIET_FIRST && n < QUIET_LAST);
            case (mode)
                FILL:        op = choose_op(85, 5, 7);
                AT_CAPACITY: op = choose_op(60, 15, 20);
                DRAIN:       op = choose_op(5, 85, 7);
                default:     op = choose_op(35, 30, 25);
            endcase
            send_request(op, pick_index(shadow_len), pick_value(), 1'b0, UNTYPED);
            case (mode)
                FILL: begin
                    if (shadow_len == CAPACITY) begin
                        mode = AT_CAPACITY;
                    end
                end
                AT_CAPACITY: begin
                    held++;
                    if (held == HOLD_AT_FULL) begin
                        mode = DRAIN;
                    end
                end
                DRAIN: begin
                    if (shadow_len <= 1) begin
                        mode = MIXED;
                    end
                end
                default: begin
                end
            endcase
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("indexed_list_store verification clean");
        end else begin
            $display("indexed_list_store verification failed");
        end
        $finish;
    end

endmodule
